[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file sfd_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/sfd_pkg.sv]
package sfd_pkg;

    localparam logic [7:0] MAGIC_BYTE = 8'hFA;
    localparam logic [7:0] END_BYTE   = 8'hFC;

    localparam logic [7:0]  HEAD_RESET  = 8'h5B;
    localparam logic [10:0] LIMIT_RESET = 11'd1024;

    // register index, taken from paddr bit 2
    localparam logic REG_HEAD  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_HEAD,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_CMD_LO,
        PH_CMD_HI,
        PH_DATA,
        PH_ALLOC,
        PH_SUM_LO,
        PH_SUM_HI,
        PH_END
    } t_phase;

    typedef enum logic [2:0] {
        EV_WAIT   = 3'd0,
        EV_DATA   = 3'd1,
        EV_OK     = 3'd2,
        EV_LONG   = 3'd3,
        EV_BADSUM = 3'd4,
        EV_BADEND = 3'd5
    } t_event;

    typedef struct packed {
        logic [7:0]  head_byte;
        logic [10:0] length_limit;
    } t_cfg;

    typedef struct packed {
        t_event      ev;
        logic [7:0]  data_byte;
        logic [9:0]  byte_index;
        logic [15:0] command;
        logic [10:0] frame_length;
        logic [7:0]  alloc_byte;
    } t_result;

endpackage

[hw/rtl/sfd_regs.sv]
module sfd_regs
    import sfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [7:0]  r_head;
    logic [10:0] r_limit;
    logic        wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= HEAD_RESET;
            r_limit <= LIMIT_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_HEAD:  r_head  <= pwdata[7:0];
                REG_LIMIT: r_limit <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_HEAD:  prdata = 32'(r_head);
            REG_LIMIT: prdata = 32'(r_limit);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg.head_byte    = r_head;
    assign o_cfg.length_limit = r_limit;

endmodule

[hw/rtl/sfd_parser.sv]
module sfd_parser
    import sfd_pkg::*;
#(
    parameter int MAX_LENGTH = 1024
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    localparam logic [15:0] MAX_LEN = 16'(MAX_LENGTH);

    t_phase      r_phase,   n_phase;
    logic [15:0] r_length,  n_length;
    logic [15:0] r_command, n_command;
    logic [10:0] r_count,   n_count;
    logic [15:0] r_sum,     n_sum;
    logic [7:0]  r_sum_lo,  n_sum_lo;
    logic [7:0]  r_alloc,   n_alloc;

    logic [15:0] limit;
    logic [15:0] len_full;
    logic [10:0] count_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_length  <= '0;
            r_command <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_sum_lo  <= '0;
            r_alloc   <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_length  <= n_length;
            r_command <= n_command;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_sum_lo  <= n_sum_lo;
            r_alloc   <= n_alloc;
        end
    end

    always_comb begin
        limit     = (16'(i_cfg.length_limit) > MAX_LEN) ? MAX_LEN : 16'(i_cfg.length_limit);
        len_full  = {i_byte, r_length[7:0]};
        count_inc = r_count + 11'd1;

        n_phase   = r_phase;
        n_length  = r_length;
        n_command = r_command;
        n_count   = r_count;
        n_sum     = r_sum;
        n_sum_lo  = r_sum_lo;
        n_alloc   = r_alloc;
        o_result  = '0;
        o_result.ev = EV_WAIT;

        case (r_phase)
            PH_HUNT: begin
                if (i_byte == MAGIC_BYTE) begin
                    n_sum   = 16'(MAGIC_BYTE);
                    n_phase = PH_HEAD;
                end
            end
            PH_HEAD: begin
                if (i_byte == i_cfg.head_byte) begin
                    n_sum   = r_sum + 16'(i_byte);
                    n_phase = PH_LEN_LO;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_LEN_LO: begin
                n_length = 16'(i_byte);
                n_sum    = r_sum + 16'(i_byte);
                n_phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_length = len_full;
                n_sum    = r_sum + 16'(i_byte);
                if (len_full > limit) begin
                    o_result.ev = EV_LONG;
                    n_phase     = PH_HUNT;
                end else begin
                    n_phase = PH_CMD_LO;
                end
            end
            PH_CMD_LO: begin
                n_command = 16'(i_byte);
                n_sum     = r_sum + 16'(i_byte);
                n_phase   = PH_CMD_HI;
            end
            PH_CMD_HI: begin
                n_command = {i_byte, r_command[7:0]};
                // high command byte counts at its weight in the sum
                n_sum     = r_sum + {i_byte, 8'h00};
                n_count   = '0;
                n_phase   = (r_length != '0) ? PH_DATA : PH_ALLOC;
            end
            PH_DATA: begin
                o_result.ev         = EV_DATA;
                o_result.data_byte  = i_byte;
                o_result.byte_index = r_count[9:0];
                n_sum   = r_sum + 16'(i_byte);
                n_count = count_inc;
                if (16'(count_inc) >= r_length) begin
                    n_phase = PH_ALLOC;
                end
            end
            PH_ALLOC: begin
                n_alloc = i_byte;
                n_sum   = r_sum + 16'(i_byte);
                n_phase = PH_SUM_LO;
            end
            PH_SUM_LO: begin
                n_sum_lo = i_byte;
                n_phase  = PH_SUM_HI;
            end
            PH_SUM_HI: begin
                if ({i_byte, r_sum_lo} != r_sum) begin
                    o_result.ev = EV_BADSUM;
                    n_phase     = PH_HUNT;
                end else begin
                    n_phase = PH_END;
                end
            end
            PH_END: begin
                if (i_byte == END_BYTE) begin
                    o_result.ev           = EV_OK;
                    o_result.command      = r_command;
                    o_result.frame_length = r_length[10:0];
                    o_result.alloc_byte   = r_alloc;
                end else begin
                    o_result.ev = EV_BADEND;
                end
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

endmodule

[hw/rtl/sum_checked_frame_deframer.sv]
// Byte-serial frame deframer: takes one received byte per transaction and returns exactly
// one result per byte (waiting, content byte with its index, frame accepted with command,
// length and alloc byte, or a too-long, bad-checksum or bad-end verdict). Frames are
// 0xFA, head byte, length (LE16), command (LE16), content, alloc, checksum (LE16), 0xFC,
// checked with a 16-bit wrapping sum. Each byte sits in an input register, one pass
// through the parser state update produces its result, and the result is held in an
// output register, so a byte can be taken every cycle while the consumer keeps up; a
// result is valid once its byte leaves the input register. Content bytes are not
// stored; keep them only if frame accepted follows. Registers: rx_head_byte at 0x0,
// length_limit at 0x4; write them only while no frame is in flight.
module sum_checked_frame_deframer
    import sfd_pkg::*;
#(
    parameter int MAX_LENGTH = 1024
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_data_byte,
    output logic [9:0]  o_byte_index,
    output logic [15:0] o_command,
    output logic [10:0] o_frame_length,
    output logic [7:0]  o_alloc_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg       cfg;
    t_result    result;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       advance;

    sfd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sfd_parser #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // byte moves from input register to output register
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_res    = r_out.ev;
    assign o_data_byte    = r_out.data_byte;
    assign o_byte_index   = r_out.byte_index;
    assign o_command      = r_out.command;
    assign o_frame_length = r_out.frame_length;
    assign o_alloc_byte   = r_out.alloc_byte;

endmodule

[hw/rtl/sfd_checker.sv]
`include "assert_macros.svh"

module sfd_checker
    import sfd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_event_res,
    input logic [7:0]  o_data_byte,
    input logic [9:0]  o_byte_index,
    input logic [15:0] o_command,
    input logic [10:0] o_frame_length,
    input logic [7:0]  o_alloc_byte,
    input logic        psel,
    input logic        pready
);

    logic [55:0] out_bus;
    logic        frame_zero;
    logic        data_zero;

    assign out_bus    = {o_event_res, o_data_byte, o_byte_index, o_command,
                         o_frame_length, o_alloc_byte};
    assign frame_zero = (o_command == '0) && (o_frame_length == '0) && (o_alloc_byte == '0);
    assign data_zero  = (o_data_byte == '0) && (o_byte_index == '0);

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(out_bus))

    // frame fields only show with an accepted frame
    `ASSERT_IMPLY(a_frame_fields, i_clk, i_rst_n, o_out_valid && (o_event_res != EV_OK), frame_zero)

    // content fields only show with a content byte
    `ASSERT_IMPLY(a_data_fields, i_clk, i_rst_n, o_out_valid && (o_event_res != EV_DATA), data_zero)

    // config port never stalls
    `ASSERT_IMPLY(a_pready, i_clk, i_rst_n, psel, pready)

endmodule

bind sum_checked_frame_deframer sfd_checker u_sfd_checker (.*);

[tb/sv/sfd_deframe_checker.sv]
`timescale 1ns / 1ps

module sfd_deframe_checker
    import sfd_pkg::*;
#(
    parameter int MAX_LENGTH = 1024
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_event_res,
    input  logic [7:0]  i_data_byte,
    input  logic [9:0]  i_byte_index,
    input  logic [15:0] i_command,
    input  logic [10:0] i_frame_length,
    input  logic [7:0]  i_alloc_byte,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending,
    output logic        o_hunting,
    output int          o_frames_ok,
    output int          o_frames_dropped
);

    // mirror of the parser and its registers
    t_cfg        cfg;
    t_phase      phase;
    logic [15:0] length_reg;
    logic [15:0] command_reg;
    logic [15:0] running_sum;
    logic [10:0] content_count;
    logic [7:0]  checksum_low;
    logic [7:0]  alloc_reg;

    t_result     parse_results_q[$];
    t_result     want;
    int          result_count;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want_v);
        // keep the log short if the block is badly broken
        if (o_fail_count < 40) begin
            $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h",
                     $time, result_count, what, got, want_v);
        end
        o_fail_count++;
    endtask

    function automatic t_result deframe_byte(input logic [7:0] b);
        t_result     r;
        logic [15:0] limit;
        r     = '0;
        r.ev  = EV_WAIT;
        limit = (cfg.length_limit > MAX_LENGTH) ? 16'(MAX_LENGTH) : 16'(cfg.length_limit);
        case (phase)
            PH_HUNT: begin
                if (b == MAGIC_BYTE) begin
                    running_sum = 16'(MAGIC_BYTE);
                    phase       = PH_HEAD;
                end
            end
            PH_HEAD: begin
                if (b == cfg.head_byte) begin
                    running_sum = running_sum + 16'(b);
                    phase       = PH_LEN_LO;
                end else begin
                    phase = PH_HUNT;
                end
            end
            PH_LEN_LO: begin
                length_reg  = 16'(b);
                running_sum = running_sum + 16'(b);
                phase       = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                length_reg[15:8] = b;
                running_sum      = running_sum + 16'(b);
                if (length_reg > limit) begin
                    r.ev  = EV_LONG;
                    phase = PH_HUNT;
                end else begin
                    phase = PH_CMD_LO;
                end
            end
            PH_CMD_LO: begin
                command_reg = 16'(b);
                running_sum = running_sum + 16'(b);
                phase       = PH_CMD_HI;
            end
            PH_CMD_HI: begin
                // the high command byte enters the sum at its full weight
                command_reg[15:8] = b;
                running_sum       = running_sum + {b, 8'h00};
                content_count     = '0;
                if (length_reg != 16'd0) begin
                    phase = PH_DATA;
                end else begin
                    phase = PH_ALLOC;
                end
            end
            PH_DATA: begin
                r.ev          = EV_DATA;
                r.data_byte   = b;
                r.byte_index  = content_count[9:0];
                running_sum   = running_sum + 16'(b);
                content_count = content_count + 11'd1;
                if (16'(content_count) >= length_reg) begin
                    phase = PH_ALLOC;
                end
            end
            PH_ALLOC: begin
                alloc_reg   = b;
                running_sum = running_sum + 16'(b);
                phase       = PH_SUM_LO;
            end
            PH_SUM_LO: begin
                checksum_low = b;
                phase        = PH_SUM_HI;
            end
            PH_SUM_HI: begin
                if ({b, checksum_low} != running_sum) begin
                    r.ev  = EV_BADSUM;
                    phase = PH_HUNT;
                end else begin
                    phase = PH_END;
                end
            end
            PH_END: begin
                if (b == END_BYTE) begin
                    r.ev           = EV_OK;
                    r.command      = command_reg;
                    r.frame_length = length_reg[10:0];
                    r.alloc_byte   = alloc_reg;
                end else begin
                    r.ev = EV_BADEND;
                end
                phase = PH_HUNT;
            end
            default: begin
                phase = PH_HUNT;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.head_byte    = HEAD_RESET;
            cfg.length_limit = LIMIT_RESET;
            phase            = PH_HUNT;
            length_reg       = '0;
            command_reg      = '0;
            running_sum      = '0;
            content_count    = '0;
            checksum_low     = '0;
            alloc_reg        = '0;
            result_count     = 0;
            o_fail_count     = 0;
            o_frames_ok      = 0;
            o_frames_dropped = 0;
            parse_results_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (parse_results_q.size() == 0) begin
                    report_mismatch("result with nothing pending, event",
                                    32'(i_event_res), 0);
                end else begin
                    want = parse_results_q.pop_front();
                    if (i_event_res != want.ev) begin
                        report_mismatch("event", 32'(i_event_res), 32'(want.ev));
                    end
                    if (i_data_byte != want.data_byte) begin
                        report_mismatch("data byte", 32'(i_data_byte), 32'(want.data_byte));
                    end
                    if (i_byte_index != want.byte_index) begin
                        report_mismatch("byte index", 32'(i_byte_index),
                                        32'(want.byte_index));
                    end
                    if (i_command != want.command) begin
                        report_mismatch("command", 32'(i_command), 32'(want.command));
                    end
                    if (i_frame_length != want.frame_length) begin
                        report_mismatch("frame length", 32'(i_frame_length),
                                        32'(want.frame_length));
                    end
                    if (i_alloc_byte != want.alloc_byte) begin
                        report_mismatch("alloc byte", 32'(i_alloc_byte),
                                        32'(want.alloc_byte));
                    end
                    if (want.ev == EV_OK) begin
                        o_frames_ok++;
                    end else if (want.ev == EV_LONG || want.ev == EV_BADSUM ||
                                 want.ev == EV_BADEND) begin
                        o_frames_dropped++;
                    end
                end
                result_count++;
            end

            if (i_in_valid && i_in_ready) begin
                parse_results_q.push_back(deframe_byte(i_rx_byte));
            end

            // a byte taken at the same edge still sees the old register value
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_HEAD) begin
                    cfg.head_byte = i_pwdata[7:0];
                end else begin
                    cfg.length_limit = i_pwdata[10:0];
                end
            end
        end
        o_pending <= parse_results_q.size();
        o_hunting <= (phase == PH_HUNT);
    end

endmodule

[tb/sv/tb_sum_checked_frame_deframer.sv]
`timescale 1ns / 1ps

module tb_sum_checked_frame_deframer
    import sfd_pkg::*;
;

    localparam int MAX_LEN        = 1024;
    localparam int NO_CUT         = 1 << 20;
    localparam int DRAIN_CYCLES   = 6;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_BYTES    = 120;

    typedef enum int {
        FAULT_NONE,
        FAULT_HEAD,
        FAULT_LONG,
        FAULT_SUM,
        FAULT_END
    } t_frame_fault;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_LIGHT
    } t_stall;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [9:0]  byte_index;
    logic [15:0] command;
    logic [10:0] frame_length;
    logic [7:0]  alloc_byte;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    logic        hunting;
    int          frames_ok;
    int          frames_dropped;

    // stimulus-side copy of the registers, used to build frames
    logic [7:0]  cfg_head  = HEAD_RESET;
    logic [10:0] cfg_limit = LIMIT_RESET;
    int          burst_left    = 0;
    int          bytes_sent    = 0;
    int          reg_writes    = 0;
    int          idle_cycles   = 0;
    bit          hold_off_req  = 1'b0;
    bit          hold_off_done = 1'b0;

    always #10 clk = ~clk;

    sum_checked_frame_deframer #(
        .MAX_LENGTH (MAX_LEN)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_event_res    (event_res),
        .o_data_byte    (data_byte),
        .o_byte_index   (byte_index),
        .o_command      (command),
        .o_frame_length (frame_length),
        .o_alloc_byte   (alloc_byte),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    sfd_deframe_checker #(
        .MAX_LENGTH (MAX_LEN)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_rx_byte        (rx_byte),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_event_res      (event_res),
        .i_data_byte      (data_byte),
        .i_byte_index     (byte_index),
        .i_command        (command),
        .i_frame_length   (frame_length),
        .i_alloc_byte     (alloc_byte),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_hunting        (hunting),
        .o_frames_ok      (frames_ok),
        .o_frames_dropped (frames_dropped)
    );

    function automatic int eff_limit();
        return (cfg_limit > MAX_LEN) ? MAX_LEN : int'(cfg_limit);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    // sends the byte unless the frame has been cut short
    task automatic put_byte(input logic [7:0] b, inout int left);
        if (left > 0) begin
            send_byte(b);
            left--;
        end
    endtask

    task automatic send_frame(input logic [15:0] len, input logic [15:0] cmd,
                              input logic [7:0] alloc, input t_frame_fault fault,
                              input int cut);
        logic [15:0] sum;
        logic [7:0]  b;
        int          left;
        left = cut;
        sum  = 16'(MAGIC_BYTE) + 16'(cfg_head) + 16'(len[7:0]) + 16'(len[15:8]) + cmd;
        put_byte(MAGIC_BYTE, left);
        if (fault == FAULT_HEAD) begin
            put_byte(cfg_head ^ 8'($urandom_range(1, 255)), left);
        end else begin
            put_byte(cfg_head, left);
            put_byte(len[7:0], left);
            put_byte(len[15:8], left);
            if (fault != FAULT_LONG) begin
                put_byte(cmd[7:0], left);
                put_byte(cmd[15:8], left);
                for (int i = 0; i < int'(len); i++) begin
                    b   = 8'($urandom);
                    sum = sum + 16'(b);
                    put_byte(b, left);
                end
                put_byte(alloc, left);
                sum = sum + 16'(alloc);
                if (fault == FAULT_SUM) begin
                    sum = sum ^ 16'($urandom_range(1, 65535));
                end
                put_byte(sum[7:0], left);
                put_byte(sum[15:8], left);
                if (fault == FAULT_END) begin
                    b = 8'($urandom);
                    // a magic byte in the end slot must not restart a frame
                    if (b == END_BYTE) b = MAGIC_BYTE;
                    put_byte(b, left);
                end else if (fault == FAULT_NONE) begin
                    put_byte(END_BYTE, left);
                end
            end
        end
    endtask

    task automatic random_frames(input int budget);
        int           start;
        int           pick;
        int           lim;
        int           cut;
        logic [15:0]  len;
        t_frame_fault fault;
        start = bytes_sent;
        lim   = eff_limit();
        while (bytes_sent - start < budget) begin
            pick  = $urandom_range(0, 99);
            cut   = NO_CUT;
            fault = FAULT_NONE;
            if (pick < 4) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else begin
                if (pick < 12) begin
                    fault = FAULT_SUM;
                end else if (pick < 18) begin
                    fault = FAULT_END;
                end else if (pick < 23) begin
                    fault = FAULT_HEAD;
                end else if (pick < 28) begin
                    fault = FAULT_LONG;
                end else if (pick < 32) begin
                    cut = $urandom_range(1, 8);
                end
                if (fault == FAULT_LONG) begin
                    len = ($urandom_range(0, 3) == 0) ? 16'(lim + 1)
                                                       : 16'($urandom_range(lim + 1, 65535));
                end else if ($urandom_range(0, 9) == 0) begin
                    len = 16'($urandom_range(0, (lim < 64) ? lim : 64));
                end else begin
                    len = 16'($urandom_range(0, (lim < 12) ? lim : 12));
                end
                send_frame(len, 16'($urandom), 8'($urandom), fault, cut);
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // brings the parser back to hunting so registers change between frames
    task automatic settle();
        drain();
        while (!hunting) begin
            repeat (16) send_byte(8'h00);
            drain();
        end
    endtask

    task automatic apb_write(input logic reg_sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
    endtask

    task automatic set_config(input logic [7:0] head, input logic [10:0] limit);
        // upper bits are junk and must be ignored by the block
        apb_write(REG_HEAD, {24'($urandom), head});
        apb_write(REG_LIMIT, {21'($urandom), limit});
        cfg_head  = head;
        cfg_limit = limit;
    endtask

    initial begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(HEAD_RESET, LIMIT_RESET);
        // magic followed by magic: the second is a bad head, not a new frame
        send_byte(MAGIC_BYTE);
        send_byte(MAGIC_BYTE);
        send_frame(16'hFFFF, 16'h0000, 8'h00, FAULT_LONG, NO_CUT);
        send_frame(16'd0, 16'hFFFF, 8'hFF, FAULT_END, NO_CUT);
        send_frame(16'd0, 16'h00FF, 8'h80, FAULT_SUM, NO_CUT);
        send_frame(16'd1, 16'h8000, 8'h01, FAULT_NONE, NO_CUT);
        random_frames(PHASE_BYTES);
        settle();

        // zero limit: only empty frames pass; receiver holds off meanwhile
        set_config(8'h00, 11'd0);
        hold_off_req = 1'b1;
        random_frames(PHASE_BYTES);
        settle();

        // limit above the build maximum is clamped
        set_config(8'hFF, 11'h7FF);
        send_frame(16'd1025, 16'($urandom), 8'($urandom), FAULT_LONG, NO_CUT);
        random_frames(PHASE_BYTES);
        settle();

        set_config(8'($urandom_range(1, 254)), 11'($urandom_range(1, 64)));
        random_frames(PHASE_BYTES);
        drain();

        $display("run covered %0d bytes under %0d register writes:", bytes_sent, reg_writes);
        $display("%0d frames accepted, %0d dropped; receiver held off for %0d cycles once",
                 frames_ok, frames_dropped, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("[sum_checked_frame_deframer] OK");
        end else begin
            $display("[sum_checked_frame_deframer] ERROR");
        end
        $finish;
    end

    initial begin : receiver
        int     seg;
        t_stall mode;
        forever begin
            if (hold_off_req && !hold_off_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end else begin
                mode = t_stall'($urandom_range(0, 3));
                seg  = $urandom_range(8, 120);
                repeat (seg) begin
                    case (mode)
                        STALL_NONE:  out_ready <= 1'b1;
                        STALL_HALF:  out_ready <= 1'($urandom_range(0, 1));
                        STALL_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
                        default:     out_ready <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // no transaction on either channel for too long means the block is stuck
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[sum_checked_frame_deframer] ERROR");
                $finish;
            end
        end
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_regs.sv
hw/rtl/sfd_parser.sv
hw/rtl/sum_checked_frame_deframer.sv
hw/rtl/sfd_checker.sv
tb/sv/sfd_deframe_checker.sv
tb/sv/tb_sum_checked_frame_deframer.sv
